// File: rtl/core/npc_pkg.sv
// Shared constants and types for the nearest palette color search core.
// No dependencies; compiled first.
package npc_pkg;

  localparam int ENTRIES    = 256;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DIST_W     = 10;
  localparam int DIST_START = 256 * 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

endpackage

// File: rtl/core/nearest_palette_color_search_core.sv
// Nearest palette color search core: palette RAM, scan sequencer, distance unit.
// Depends on npc_pkg, npc_ram and npc_dist.
//
// A write transfer stores one palette entry. A query transfer
// scans the palette from index 0 with one shared distance unit fed by the single
// RAM read port, one entry per cycle: the registered RAM read feeds the distance
// unit, each entry is compared in turn, and the winner then goes to the output
// register; the scan ends early on an exact match. The input is not ready
// during a scan, nor while a finished result waits for the output register to
// be taken. The palette reads as zero after reset through per-entry valid
// bits, so there is no clearing pass.
module nearest_palette_color_search_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // color_index[7:0]
);
  import npc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               valid_q_r, valid_q_nxt;
  rgb_t               qcol_r, qcol_nxt;
  logic [IDX_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               rd_act_r, rd_act_nxt;
  logic [DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;

  logic               in_fire;
  logic               wr_ok;
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   wr_addr;
  rgb_t               in_col;
  rgb_t               ram_rdata;
  rgb_t               entry_col;
  logic [DIST_W-1:0]  dist_sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_col     = '{blue: in_tdata[31:24], green: in_tdata[23:16], red: in_tdata[15:8]};
  assign wr_ok      = 32'(in_tdata[7:0]) < ENTRIES;
  assign wr_addr    = IDX_W'(in_tdata[7:0]);
  assign ram_we     = in_fire && (in_tuser[0] == OP_WRITE) && wr_ok;
  assign ram_re     = (state_r == ST_SCAN);
  assign entry_col  = valid_q_r ? ram_rdata : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  npc_ram #(
    .WIDTH($bits(rgb_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(in_col),
    .re   (ram_re),
    .raddr(rd_addr_r),
    .rdata(ram_rdata)
  );

  npc_dist u_dist (
    .query   (qcol_r),
    .entry   (entry_col),
    .dist_sum(dist_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    valid_q_nxt   = valid_q_r;
    qcol_nxt      = qcol_r;
    rd_addr_nxt   = rd_addr_r;
    cmp_idx_nxt   = cmp_idx_r;
    rd_act_nxt    = rd_act_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ram_we) begin
      valid_nxt[wr_addr] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser[0] == OP_QUERY)) begin
          qcol_nxt      = in_col;
          rd_addr_nxt   = '0;
          rd_act_nxt    = 1'b0;
          best_dist_nxt = DIST_W'(DIST_START);
          best_idx_nxt  = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        valid_q_nxt = valid_r[rd_addr_r];
        cmp_idx_nxt = rd_addr_r;
        rd_act_nxt  = 1'b1;
        if (rd_addr_r != LAST_IDX) begin
          rd_addr_nxt = rd_addr_r + 1'b1;
        end
        if (rd_act_r) begin
          if (dist_sum < best_dist_r) begin
            best_dist_nxt = dist_sum;
            best_idx_nxt  = cmp_idx_r;
          end
          if ((dist_sum == '0) || (cmp_idx_r == LAST_IDX)) begin
            rd_act_nxt = 1'b0;
            state_nxt  = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'(best_idx_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      rd_act_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_act_r    <= rd_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
    valid_q_r   <= valid_q_nxt;
    qcol_r      <= qcol_nxt;
    rd_addr_r   <= rd_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser[0] == OP_QUERY)) |=>
      ((state_r == ST_SCAN) && (best_dist_r == DIST_W'(DIST_START)) && !rd_act_r))
    else $error("query transfer did not start a fresh scan");

  a_exact_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && rd_act_r && (dist_sum == '0)) |=>
      ((state_r == ST_WAIT) && (best_dist_r == '0)))
    else $error("exact match did not end the scan");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WAIT) && (!out_valid_r || out_tready)) |=>
      (out_tvalid && (out_tdata == 8'($past(best_idx_r))) && in_tready))
    else $error("result not loaded from the scan winner");

  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_act_r |-> ((32'(cmp_idx_r) < ENTRIES) && (state_r == ST_SCAN)))
    else $error("compare stage active outside a scan");

endmodule

// File: rtl/core/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/npc_dist.sv
// Manhattan RGB distance unit: |dr| + |dg| + |db|.
// Depends on npc_pkg.
module npc_dist (
  input  npc_pkg::rgb_t              query,
  input  npc_pkg::rgb_t              entry,
  output logic [npc_pkg::DIST_W-1:0] dist_sum
);
  import npc_pkg::*;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [7:0] dr;
  logic [7:0] dg;
  logic [7:0] db;

  assign dr       = absdiff(query.red, entry.red);
  assign dg       = absdiff(query.green, entry.green);
  assign db       = absdiff(query.blue, entry.blue);
  assign dist_sum = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);

endmodule
